FILE: hw/rtl/hss_pkg.sv
package hss_pkg;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_KEY_LO  = 2'd0;
  localparam logic [1:0] REG_KEY_HI  = 2'd1;
  localparam logic [1:0] REG_KEY_LEN = 2'd2;

  // request codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  // ascii codes used by the folding rules
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_LOW_A = 8'h61;
  localparam logic [7:0] CHR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // search flags carried between the match logic and the state register
  typedef struct packed {
    logic match_found;
    logic after_newline;
  } hss_flags_t;

endpackage

FILE: hw/rtl/hss_match.sv
module hss_match
  import hss_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic [63:0]              key_lo,
  input  logic [63:0]              key_hi,
  input  logic [4:0]               key_length,
  input  logic                     req,
  input  logic [7:0]               chr_in,
  input  logic [MAX_KEY_BYTES-1:0] pm,
  input  hss_flags_t               flags,
  output logic [MAX_KEY_BYTES-1:0] pm_next,
  output hss_flags_t               flags_next
);

  localparam logic [4:0] LEN_SAT = 5'((MAX_KEY_BYTES > 31) ? 31 : MAX_KEY_BYTES);

  logic [7:0]               key_arr [MAX_KEY_BYTES];
  logic [4:0]               len_eff;
  logic [7:0]               chr_up;
  logic [7:0]               chr;
  logic                     clear;
  logic                     nl_now;
  logic                     skip;
  logic [MAX_KEY_BYTES-1:0] pm_base;
  logic [MAX_KEY_BYTES-1:0] adv;
  logic [MAX_KEY_BYTES-1:0] hit_k;
  logic [MAX_KEY_BYTES-1:0] grow;
  logic                     hit;

  // key bytes, positions past the two registers read as zero
  for (genvar k = 0; k < MAX_KEY_BYTES; k++) begin : g_key
    if (k < 8) begin : g_lo
      assign key_arr[k] = key_lo[8*k +: 8];
    end else if (k < 16) begin : g_hi
      assign key_arr[k] = key_hi[8*(k-8) +: 8];
    end else begin : g_zero
      assign key_arr[k] = 8'h00;
    end
  end

  // effective key length, zero means one, clipped to the array size
  always_comb begin
    if (key_length == 5'd0) begin
      len_eff = 5'd1;
    end else if (int'(key_length) > MAX_KEY_BYTES) begin
      len_eff = LEN_SAT;
    end else begin
      len_eff = key_length;
    end
  end

  // upper-case, line folding and skipping of line ends
  always_comb begin
    if (chr_in >= CHR_LOW_A && chr_in <= CHR_LOW_Z) begin
      chr_up = chr_in - CASE_DIFF;
    end else begin
      chr_up = chr_in;
    end
    if (flags.after_newline) begin
      clear = !(chr_up == CHR_SPACE || chr_up == CHR_TAB);
      chr   = CHR_SPACE;
    end else begin
      clear = 1'b0;
      chr   = chr_up;
    end
    nl_now  = (chr == CHR_LF);
    skip    = (chr == CHR_CR) || (chr == CHR_LF);
    pm_base = clear ? '0 : pm;
  end

  // first key byte starts a new partial match
  assign adv[0]   = (chr == key_arr[0]);
  assign hit_k[0] = adv[0] && (len_eff == 5'd1);
  assign grow[0]  = 1'b0;

  // every active partial match advances or dies in parallel
  for (genvar k = 1; k < MAX_KEY_BYTES; k++) begin : g_adv
    assign adv[k]   = pm_base[k] && (k < int'(len_eff)) && (key_arr[k] == chr);
    assign hit_k[k] = adv[k] && (int'(len_eff) == k + 1);
    assign grow[k]  = adv[k-1] && (int'(len_eff) != k);
  end

  assign hit = |hit_k;

  // state update for one word
  always_comb begin
    pm_next    = pm;
    flags_next = flags;
    if (req == REQ_RESET) begin
      pm_next                = '0;
      flags_next.match_found = 1'b0;
    end else if (!flags.match_found) begin
      flags_next.after_newline = nl_now;
      if (skip) begin
        pm_next = pm_base;
      end else begin
        pm_next                = grow;
        flags_next.match_found = hit;
      end
    end
  end

endmodule

FILE: hw/rtl/header_substring_search_unit.sv
// Case-insensitive key search over a stream of header bytes. Each word on
// the header channel is either a byte (req_type 0) or a search reset
// (req_type 1); every word yields one result word carrying the found flag.
// The block takes one word per clock cycle while the result channel does not
// stall: a word is held in an input register while the parallel match update
// and the flags are computed, then moves to the result register. The rate
// is set by the single state update that each byte makes to the
// partial-match vector. The key (up to 16 bytes, already upper case) and its
// length are written over the APB port at byte addresses 0, 8 and 16; the user
// must write them only while the stream is idle, the block does not enforce it.
module header_substring_search_unit
  import hss_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // header channel
  input  logic        hdr_valid,
  output logic        hdr_stall,
  input  logic        req_type,
  input  logic [7:0]  header_byte,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        found,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]              key_lo;
  logic [63:0]              key_hi;
  logic [4:0]               key_length;
  logic                     in_full;
  logic                     in_req;
  logic [7:0]               in_byte;
  logic                     move;
  logic [MAX_KEY_BYTES-1:0] pm;
  logic [MAX_KEY_BYTES-1:0] pm_next;
  hss_flags_t               flags;
  hss_flags_t               flags_next;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_lo     <= '0;
      key_hi     <= '0;
      key_length <= 5'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_KEY_LO:  key_lo     <= pwdata;
        REG_KEY_HI:  key_hi     <= pwdata;
        REG_KEY_LEN: key_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_KEY_LO:  prdata = key_lo;
      REG_KEY_HI:  prdata = key_hi;
      REG_KEY_LEN: prdata = {59'd0, key_length};
      default:     prdata = '0;
    endcase
  end

  // handshake: the input register drains whenever the result slot frees
  assign move      = !res_valid || !res_stall;
  assign hdr_stall = in_full && !move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!hdr_stall) begin
      in_full <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hdr_stall) begin
      in_req  <= req_type;
      in_byte <= header_byte;
    end
  end

  // match logic
  hss_match #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_match (
    .key_lo    (key_lo),
    .key_hi    (key_hi),
    .key_length(key_length),
    .req       (in_req),
    .chr_in    (in_byte),
    .pm        (pm),
    .flags     (flags),
    .pm_next   (pm_next),
    .flags_next(flags_next)
  );

  // search state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pm        <= '0;
      flags     <= '0;
      res_valid <= 1'b0;
    end else if (move) begin
      res_valid <= in_full;
      if (in_full) begin
        pm    <= pm_next;
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move && in_full) begin
      found <= flags_next.match_found;
    end
  end

  // a reset request always reports not found
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (move && in_full && in_req == REQ_RESET) |=> (res_valid && !found))
    else $error("reset request did not clear found");

  // found stays set until a reset request passes
  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    (flags.match_found && !(move && in_full && in_req == REQ_RESET))
    |=> flags.match_found)
    else $error("found flag dropped without reset request");

  // a stalled result keeps the search state frozen
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> ($stable(pm) && $stable(flags)))
    else $error("search state moved while result stalled");

  // no partial match of zero bytes is ever recorded
  a_no_empty_match: assert property (@(posedge clk) disable iff (rst)
    !pm[0])
    else $error("partial match bit zero set");

endmodule

FILE: tb/tb_header_substring_search_unit.sv
module tb_header_substring_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hss_pkg::*;

  localparam int KEY_MAX = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 950;
  localparam logic [7:0] CHR_UP_A = CHR_LOW_A - CASE_DIFF;
  localparam logic [7:0] CHR_UP_Z = CHR_LOW_Z - CASE_DIFF;

  // dut ports
  logic        clk;
  logic        rst;
  logic        hdr_valid;
  logic        hdr_stall;
  logic        req_type;
  logic [7:0]  header_byte;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        found;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  header_substring_search_unit #(.MAX_KEY_BYTES(KEY_MAX)) dut (
    .clk         (clk),
    .rst         (rst),
    .hdr_valid   (hdr_valid),
    .hdr_stall   (hdr_stall),
    .req_type    (req_type),
    .header_byte (header_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .found       (found),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // directed plan: register writes and words, some with a hand-checked flag
  typedef struct {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    logic        req;
    logic [7:0]  hbyte;
    logic        fixed;
    logic        fixed_found;
  } plan_row_t;

  plan_row_t plan[$];

  // search model state and its copy of the key registers
  logic [63:0]        key_lo = '0;
  logic [63:0]        key_hi = '0;
  logic [4:0]         key_len_code = 5'd1;
  logic [KEY_MAX-1:0] match_vec = '0;
  logic               key_seen = 1'b0;
  logic               after_lf = 1'b0;

  logic pending_found[$];
  int   err_cnt = 0;
  int   live_words = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  int   len_pick[5] = '{1, 16, 0, 31, 2};
  logic exp_found;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] key_at(int pos);
    if (pos < 8) return key_lo[pos*8 +: 8];
    return key_hi[(pos-8)*8 +: 8];
  endfunction

  // length code 0 acts as 1, codes above the maximum saturate
  function automatic int eff_len();
    int len;
    len = int'(key_len_code);
    if (len == 0) len = 1;
    if (len > KEY_MAX) len = KEY_MAX;
    return len;
  endfunction

  // advance the search by one word, return the found flag after it
  function automatic logic search_step(logic req, logic [7:0] b);
    logic [7:0]         c;
    logic [KEY_MAX-1:0] nxt;
    logic               hit;
    int                 len;
    c = b;
    nxt = '0;
    hit = 1'b0;
    len = eff_len();
    if (req == REQ_RESET) begin
      match_vec = '0;
      key_seen = 1'b0;
    end else if (!key_seen) begin
      if (c >= CHR_LOW_A && c <= CHR_LOW_Z) c = c - CASE_DIFF;
      // byte after a line feed: folding keeps matches, anything else kills them
      if (after_lf) begin
        if (c != CHR_SPACE && c != CHR_TAB) match_vec = '0;
        c = CHR_SPACE;
      end
      after_lf = (c == CHR_LF);
      if (c != CHR_CR && c != CHR_LF) begin
        for (int k = 1; k < len; k++) begin
          if (match_vec[k] && key_at(k) == c) begin
            if (k + 1 == len) hit = 1'b1;
            else nxt[k+1] = 1'b1;
          end
        end
        if (c == key_at(0)) begin
          if (len == 1) hit = 1'b1;
          else nxt[1] = 1'b1;
        end
        match_vec = nxt;
        if (hit) key_seen = 1'b1;
      end
    end
    return key_seen;
  endfunction

  function automatic plan_row_t cfg_row(logic [1:0] idx, logic [63:0] val);
    plan_row_t r;
    r = '{1'b1, idx, val, REQ_BYTE, 8'h00, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic plan_row_t word_row(logic req, logic [7:0] b, logic fixed, logic f);
    plan_row_t r;
    r = '{1'b0, REG_KEY_LO, 64'd0, req, b, fixed, f};
    return r;
  endfunction

  // send one word in bursts with gaps, then record its expected flag
  task automatic send_word(logic req, logic [7:0] b, logic fixed, logic fixed_found);
    logic taken;
    logic live;
    logic pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        hdr_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    hdr_valid <= 1'b1;
    req_type <= req;
    header_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !hdr_stall;
      @(posedge clk);
    end
    live = (req == REQ_RESET) || !key_seen;
    pred = search_step(req, b);
    if (live) live_words++;
    pending_found.push_back(fixed ? fixed_found : pred);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(REQ_BYTE, b, 1'b0, 1'b0);
  endtask

  task automatic send_search_reset();
    send_word(REQ_RESET, 8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // stop the stream and let every result come out
  task automatic drain();
    hdr_valid <= 1'b0;
    do @(posedge clk); while (pending_found.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup phase, access phase held until pready, then idle with psel low
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    logic rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_LO:  key_lo = val;
      REG_KEY_HI:  key_hi = val;
      REG_KEY_LEN: key_len_code = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // filler byte: raw, line control, near-key or letters
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0, 1: return 8'($urandom_range(255));
      2: return key_at($urandom_range(eff_len() - 1)) ^ ($urandom_range(1) ? 8'h00 : CASE_DIFF);
      3: begin
        case ($urandom_range(3))
          0: return CHR_CR;
          1: return CHR_LF;
          2: return CHR_SPACE;
          default: return CHR_TAB;
        endcase
      end
      default: return 8'($urandom_range(CHR_UP_A, CHR_LOW_Z));
    endcase
  endfunction

  // key prefix with random case, stray carriage returns and folds at spaces
  task automatic send_key(int upto, bit spoil);
    logic [7:0] kb;
    int         bad_pos;
    bad_pos = -1;
    if (spoil) bad_pos = $urandom_range(upto - 1);
    for (int p = 0; p < upto; p++) begin
      kb = key_at(p);
      if (p == bad_pos) kb = 8'($urandom_range(255));
      if ($urandom_range(11) == 0) send_byte(CHR_CR);
      if (kb == CHR_SPACE && $urandom_range(2) == 0) begin
        send_byte(CHR_LF);
        send_byte($urandom_range(1) ? CHR_TAB : CHR_SPACE);
      end else if (kb >= CHR_UP_A && kb <= CHR_UP_Z && $urandom_range(1) == 1) begin
        send_byte(kb + CASE_DIFF);
      end else begin
        send_byte(kb);
      end
    end
  endtask

  // result checker, samples mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_found.size() == 0) begin
        $display("%0t: result word with nothing pending, got found=%0b", $time, found);
        err_cnt++;
      end else begin
        exp_found = pending_found.pop_front();
        if (found !== exp_found) begin
          $display("%0t: found mismatch, expected %0b, got %0b", $time, exp_found, found);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall pattern, mode changes every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(3) == 0);
      2: res_stall <= ((stall_left % 11) < 6);
      default: res_stall <= ($urandom_range(1) == 0);
    endcase
  end

  // watchdog on cycles with no handshake of any kind
  always @(negedge clk) begin
    if (rst || (hdr_valid && !hdr_stall) || (res_valid && !res_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int         phase_no;
    int         phase_end;
    int         seg;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  kb;
    logic [4:0]  code;

    rst <= 1'b1;
    hdr_valid <= 1'b0;
    req_type <= REQ_BYTE;
    header_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the key is a single zero byte
    plan.push_back(word_row(REQ_BYTE, 8'h41, 1'b1, 1'b0));
    plan.push_back(word_row(REQ_BYTE, 8'h00, 1'b1, 1'b1));
    plan.push_back(word_row(REQ_BYTE, 8'hFF, 1'b1, 1'b1));
    plan.push_back(word_row(REQ_RESET, 8'hA5, 1'b1, 1'b0));
    // "HOST", lower-case input
    plan.push_back(cfg_row(REG_KEY_LO, 64'h0000_0000_5453_4F48));
    plan.push_back(cfg_row(REG_KEY_LEN, 64'd4));
    plan.push_back(word_row(REQ_BYTE, "h", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, "o", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, "s", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, "t", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_RESET, 8'h5A, 1'b1, 1'b0));
    // line feed after line feed is compared as a space
    plan.push_back(word_row(REQ_BYTE, "H", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, "O", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, CHR_LF, 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, CHR_LF, 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, "S", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, "T", 1'b0, 1'b0));
    // length zero acts as one
    plan.push_back(cfg_row(REG_KEY_LEN, 64'd0));
    plan.push_back(word_row(REQ_BYTE, "h", 1'b0, 1'b0));
    plan.push_back(word_row(REQ_RESET, 8'hFF, 1'b1, 1'b0));
    // all-ones key, length saturates, high bytes are not case folded
    plan.push_back(cfg_row(REG_KEY_LO, '1));
    plan.push_back(cfg_row(REG_KEY_HI, '1));
    plan.push_back(cfg_row(REG_KEY_LEN, 64'd31));
    plan.push_back(word_row(REQ_BYTE, 8'hE1, 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, 8'h7F, 1'b0, 1'b0));
    plan.push_back(word_row(REQ_BYTE, 8'hFF, 1'b0, 1'b0));
    plan.push_back(cfg_row(REG_KEY_LO, 64'd0));
    plan.push_back(cfg_row(REG_KEY_HI, 64'd0));
    plan.push_back(cfg_row(REG_KEY_LEN, 64'd16));
    plan.push_back(word_row(REQ_BYTE, 8'h00, 1'b0, 1'b0));
    plan.push_back(word_row(REQ_RESET, 8'h00, 1'b1, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_word(plan[i].req, plan[i].hbyte, plan[i].fixed, plan[i].fixed_found);
      end
    end

    // random phases, each with a fresh key and length
    live_words = 0;
    phase_no = 0;
    while (live_words < RANDOM_WORDS) begin
      drain();
      if (phase_no < 5) code = 5'(len_pick[phase_no]);
      else code = 5'($urandom_range(31));
      lo = '0;
      hi = '0;
      for (int p = 0; p < KEY_MAX; p++) begin
        case (phase_no % 3)
          0: begin
            case ($urandom_range(4))
              0: kb = "A";
              1: kb = "B";
              2: kb = "-";
              3: kb = CHR_SPACE;
              default: kb = ":";
            endcase
          end
          1: kb = 8'($urandom_range(255));
          default: kb = 8'($urandom_range(CHR_UP_A, CHR_UP_Z));
        endcase
        if (p < 8) lo[p*8 +: 8] = kb;
        else hi[(p-8)*8 +: 8] = kb;
      end
      write_reg(REG_KEY_LO, lo);
      write_reg(REG_KEY_HI, hi);
      write_reg(REG_KEY_LEN, {59'd0, code});
      phase_no++;

      phase_end = live_words + $urandom_range(50, 110);
      while (live_words < phase_end) begin
        seg = $urandom_range(9);
        if (seg < 5) begin
          repeat ($urandom_range(4)) send_byte(noise_byte());
          send_key(eff_len(), $urandom_range(5) == 0);
        end else if (seg < 7) begin
          send_key($urandom_range(1, eff_len()), 1'b0);
          send_key(eff_len(), 1'b0);
        end else if (seg < 9) begin
          repeat ($urandom_range(1, 8)) send_byte(noise_byte());
        end else begin
          send_search_reset();
        end
        // once found, up to two ignored bytes and then a new search
        if (key_seen) begin
          repeat ($urandom_range(2)) send_byte(noise_byte());
          send_search_reset();
        end
      end
    end

    hdr_valid <= 1'b0;
    do @(posedge clk); while (pending_found.size() != 0);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_found.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
